// ===== design/lsa_pkg.sv =====
`default_nettype none
package lsa_pkg;

  localparam int NUM_BUCKETS      = 256;
  localparam int SLOTS_PER_BUCKET = 32;
  localparam int KEY_BITS         = 32;

  localparam int BUCKET_W = $clog2(NUM_BUCKETS);
  localparam int SLOT_W   = $clog2(SLOTS_PER_BUCKET);
  localparam int TOTAL    = NUM_BUCKETS * SLOTS_PER_BUCKET;
  localparam int ADDR_W   = BUCKET_W + SLOT_W;
  localparam int CNT_W    = 6;
  localparam int KV_W     = KEY_BITS + 1;

  typedef enum logic [1:0] {
    MODE_PROMOTE = 2'd0,
    MODE_ALLOC   = 2'd1,
    MODE_WRITE   = 2'd2,
    MODE_NOP     = 2'd3
  } mode_e;

  typedef enum logic [2:0] {
    ST_DONE    = 3'd0,
    ST_FREE    = 3'd1,
    ST_EVICT   = 3'd2,
    ST_OFF_END = 3'd3,
    ST_EMPTY   = 3'd4
  } status_e;

  typedef enum logic [8:0] {
    S_CLR   = 9'b000000001,
    S_IDLE  = 9'b000000010,
    S_FETCH = 9'b000000100,
    S_PWALK = 9'b000001000,
    S_SCAN1 = 9'b000010000,
    S_ALEN  = 9'b000100000,
    S_ARD   = 9'b001000000,
    S_AKEY  = 9'b010000000,
    S_SCAN2 = 9'b100000000
  } state_e;

endpackage
`default_nettype wire

// ===== design/lsa_ram.sv =====
`default_nettype none
module lsa_ram #(
  parameter int Width = 8,
  parameter int Depth = 256
) (
  input  wire logic                                   clk_i,
  input  wire logic                                   we_i,
  input  wire logic [((Depth > 1) ? $clog2(Depth) : 1)-1:0] waddr_i,
  input  wire logic [Width-1:0]                       wdata_i,
  input  wire logic [((Depth > 1) ? $clog2(Depth) : 1)-1:0] raddr_i,
  output logic      [Width-1:0]                       rdata_o
);

  logic [Width-1:0] mem_q [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule
`default_nettype wire

// ===== design/lru_slot_allocator.sv =====
`default_nettype none
// Channel   Direction  Handshake              Word
// command   in         start_i, busy_o        mode, bucket, slot, need, valid, key
// result    out        done_o (one cycle)     start_slot_o, status_o
//
// Slot write and no-op answer in the cycle after acceptance. Promote walks
// the recency memory read-modify-write, one recency entry per cycle.
// Allocate runs the free-run scan and, if that fails on a non-empty recency
// list, the eviction scan, one key/valid word per cycle. After reset the
// block clears the key/valid and length memories with busy_o high.
// The receiver cannot stall: each result word shows for one cycle.
module lru_slot_allocator (
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  input  wire logic                 start_i,
  output logic                      busy_o,
  input  wire logic [1:0]           mode_i,
  input  wire logic [7:0]           bucket_index_i,
  input  wire logic [4:0]           slot_i,
  input  wire logic [5:0]           slots_needed_i,
  input  wire logic                 valid_in_i,
  input  wire logic [31:0]          key_in_i,
  output logic                      done_o,
  output logic [5:0]                start_slot_o,
  output logic [2:0]                status_o
);
  import lsa_pkg::*;

  state_e state_q, state_d;
  logic [CNT_W-1:0] p_q, p_d, avail_q, avail_d, len_q, len_d, need_q, need_d;
  logic [SLOT_W-1:0] carry_q, carry_d, slot_q, slot_d;
  logic [KEY_BITS-1:0] key_q, key_d;
  logic [BUCKET_W-1:0] bucket_q, bucket_d;
  mode_e mode_q, mode_d;
  logic [ADDR_W-1:0] clr_q, clr_d;
  logic done_q, done_d;
  logic [5:0] start_slot_q, start_slot_d;
  logic [2:0] status_q, status_d;

  logic rec_we, kv_we, len_we;
  logic [ADDR_W-1:0] rec_waddr, rec_raddr, kv_waddr, kv_raddr;
  logic [SLOT_W-1:0] rec_wdata, rec_rdata;
  logic [KV_W-1:0] kv_wdata, kv_rdata;
  logic [BUCKET_W-1:0] len_waddr, len_raddr;
  logic [CNT_W-1:0] len_wdata, len_rdata, p_inc, p_sat;
  logic kv_valid;
  logic [KEY_BITS-1:0] kv_key;

  lsa_ram #(.Width(SLOT_W), .Depth(TOTAL)) u_rec (
    .clk_i, .we_i(rec_we), .waddr_i(rec_waddr), .wdata_i(rec_wdata),
    .raddr_i(rec_raddr), .rdata_o(rec_rdata));

  lsa_ram #(.Width(KV_W), .Depth(TOTAL)) u_kv (
    .clk_i, .we_i(kv_we), .waddr_i(kv_waddr), .wdata_i(kv_wdata),
    .raddr_i(kv_raddr), .rdata_o(kv_rdata));

  lsa_ram #(.Width(CNT_W), .Depth(NUM_BUCKETS)) u_len (
    .clk_i, .we_i(len_we), .waddr_i(len_waddr), .wdata_i(len_wdata),
    .raddr_i(len_raddr), .rdata_o(len_rdata));

  assign kv_valid = kv_rdata[KV_W-1];
  assign kv_key   = kv_rdata[KEY_BITS-1:0];
  assign p_inc    = p_q + CNT_W'(1);
  assign p_sat    = (p_q >= need_q) ? (p_q - need_q) : '0;

  always_comb begin
    state_d = state_q;
    p_d = p_q; avail_d = avail_q; len_d = len_q; need_d = need_q;
    carry_d = carry_q; slot_d = slot_q; key_d = key_q;
    bucket_d = bucket_q; mode_d = mode_q; clr_d = clr_q;
    done_d = 1'b0; start_slot_d = start_slot_q; status_d = status_q;

    rec_we = 1'b0;
    rec_waddr = {bucket_q, p_q[SLOT_W-1:0]};
    rec_wdata = carry_q;
    rec_raddr = {bucket_q, p_inc[SLOT_W-1:0]};
    kv_we = 1'b0;
    kv_waddr = {bucket_index_i, slot_i};
    kv_wdata = {valid_in_i, key_in_i[KEY_BITS-1:0]};
    kv_raddr = {bucket_q, p_inc[SLOT_W-1:0]};
    len_we = 1'b0;
    len_waddr = bucket_q;
    len_wdata = len_q + CNT_W'(1);
    len_raddr = bucket_index_i;

    unique case (state_q)
      S_CLR: begin
        kv_we = 1'b1;
        kv_waddr = clr_q;
        kv_wdata = '0;
        len_we = 1'b1;
        len_waddr = clr_q[BUCKET_W-1:0];
        len_wdata = '0;
        clr_d = clr_q + ADDR_W'(1);
        if (clr_q == ADDR_W'(TOTAL - 1)) begin
          state_d = S_IDLE;
        end
      end
      S_IDLE: begin
        if (start_i) begin
          mode_d = mode_e'(mode_i);
          bucket_d = bucket_index_i;
          slot_d = slot_i;
          need_d = slots_needed_i;
          start_slot_d = '0;
          status_d = ST_DONE;
          unique case (mode_e'(mode_i))
            MODE_PROMOTE, MODE_ALLOC: state_d = S_FETCH;
            MODE_WRITE: begin
              kv_we = 1'b1;
              done_d = 1'b1;
            end
            MODE_NOP: done_d = 1'b1;
            default: done_d = 1'b1;
          endcase
        end
      end
      S_FETCH: begin
        len_d = len_rdata;
        p_d = '0;
        avail_d = '0;
        carry_d = slot_q;
        rec_raddr = {bucket_q, {SLOT_W{1'b0}}};
        kv_raddr = {bucket_q, {SLOT_W{1'b0}}};
        state_d = (mode_q == MODE_PROMOTE) ? S_PWALK : S_SCAN1;
      end
      S_PWALK: begin
        // Each entry takes the one before it until the slot itself turns up.
        if (p_q == len_q) begin
          if (len_q < CNT_W'(SLOTS_PER_BUCKET)) begin
            rec_we = 1'b1;
            len_we = 1'b1;
          end
          done_d = 1'b1;
          state_d = S_IDLE;
        end else begin
          rec_we = 1'b1;
          if (rec_rdata == slot_q) begin
            done_d = 1'b1;
            state_d = S_IDLE;
          end else begin
            carry_d = rec_rdata;
            p_d = p_inc;
          end
        end
      end
      S_SCAN1: begin
        if (avail_q >= need_q || p_q == CNT_W'(SLOTS_PER_BUCKET)) begin
          if (avail_q >= need_q) begin
            done_d = 1'b1;
            start_slot_d = p_sat;
            status_d = ST_FREE;
            state_d = S_IDLE;
          end else if (len_q == '0) begin
            done_d = 1'b1;
            status_d = ST_EMPTY;
            state_d = S_IDLE;
          end else begin
            state_d = S_ALEN;
          end
        end else begin
          avail_d = kv_valid ? '0 : avail_q + CNT_W'(1);
          p_d = p_inc;
        end
      end
      S_ALEN: begin
        len_wdata = len_q - CNT_W'(1);
        rec_raddr = {bucket_q, len_wdata[SLOT_W-1:0]};
        state_d = S_ARD;
      end
      S_ARD: begin
        p_d = CNT_W'(rec_rdata);
        kv_raddr = {bucket_q, rec_rdata};
        state_d = S_AKEY;
      end
      S_AKEY: begin
        key_d = kv_key;
        kv_raddr = {bucket_q, p_q[SLOT_W-1:0]};
        state_d = S_SCAN2;
      end
      S_SCAN2: begin
        if (avail_q >= need_q || p_q == CNT_W'(SLOTS_PER_BUCKET)) begin
          done_d = 1'b1;
          start_slot_d = p_sat;
          status_d = (avail_q >= need_q) ? ST_EVICT : ST_OFF_END;
          state_d = S_IDLE;
        end else begin
          if (kv_valid && kv_key == key_q) begin
            avail_d = avail_q + CNT_W'(1);
          end
          p_d = p_inc;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_CLR;
      clr_q <= '0;
      done_q <= 1'b0;
      p_q <= '0;
      avail_q <= '0;
      len_q <= '0;
    end else begin
      state_q <= state_d;
      clr_q <= clr_d;
      done_q <= done_d;
      p_q <= p_d;
      avail_q <= avail_d;
      len_q <= len_d;
    end
  end

  always_ff @(posedge clk_i) begin
    need_q <= need_d;
    carry_q <= carry_d;
    slot_q <= slot_d;
    key_q <= key_d;
    bucket_q <= bucket_d;
    mode_q <= mode_d;
    start_slot_q <= start_slot_d;
    status_q <= status_d;
  end

  assign busy_o       = (state_q != S_IDLE);
  assign done_o       = done_q;
  assign start_slot_o = start_slot_q;
  assign status_o     = status_q;

  a_no_result_in_clear: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == S_CLR |-> !done_q) else $error("result during clearing pass");
  a_scan_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_SCAN1 || state_q == S_SCAN2 || state_q == S_PWALK)
    |-> p_q <= CNT_W'(SLOTS_PER_BUCKET)) else $error("scan pointer past bucket");
  a_len_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == S_PWALK |-> len_q <= CNT_W'(SLOTS_PER_BUCKET))
    else $error("recency list too long");

endmodule
`default_nettype wire

// ===== tb/tb_lru_slot_allocator.sv =====
module tb_lru_slot_allocator;
  import lsa_pkg::*;

  logic        clk_i = 1'b0;
  logic        rst_ni;
  logic        start_i;
  logic        busy_o;
  logic [1:0]  mode_i;
  logic [7:0]  bucket_index_i;
  logic [4:0]  slot_i;
  logic [5:0]  slots_needed_i;
  logic        valid_in_i;
  logic [31:0] key_in_i;
  logic        done_o;
  logic [5:0]  start_slot_o;
  logic [2:0]  status_o;

  lru_slot_allocator dut (
    .clk_i(clk_i), .rst_ni(rst_ni), .start_i(start_i), .busy_o(busy_o),
    .mode_i(mode_i), .bucket_index_i(bucket_index_i), .slot_i(slot_i),
    .slots_needed_i(slots_needed_i), .valid_in_i(valid_in_i), .key_in_i(key_in_i),
    .done_o(done_o), .start_slot_o(start_slot_o), .status_o(status_o)
  );

  typedef struct packed {
    logic [5:0] start_slot;
    status_e    status;
  } answer_t;

  // Shadow of the block's bucket state.
  logic [4:0]          order_mem [NUM_BUCKETS][SLOTS_PER_BUCKET];
  int unsigned         len_mem   [NUM_BUCKETS];
  logic                valid_mem [NUM_BUCKETS][SLOTS_PER_BUCKET];
  logic [KEY_BITS-1:0] key_mem   [NUM_BUCKETS][SLOTS_PER_BUCKET];

  answer_t pending_answers[$];
  int      errors = 0;
  // Buckets that the random part mostly works in, so that lists and runs build up.
  logic [7:0] hot_bucket [4];

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  function automatic void shadow_promote(int b, int s);
    int pos;
    pos = len_mem[b];
    for (int i = 0; i < len_mem[b]; i++) begin
      if (order_mem[b][i] == s) begin
        pos = i;
        break;
      end
    end
    if (pos == len_mem[b]) begin
      if (len_mem[b] >= SLOTS_PER_BUCKET) return;
      len_mem[b]++;
    end
    for (int i = pos; i > 0; i--) order_mem[b][i] = order_mem[b][i-1];
    order_mem[b][0] = s[4:0];
  endfunction

  function automatic answer_t shadow_allocate(int b, int need);
    answer_t a;
    int s;
    int avail;
    logic [KEY_BITS-1:0] k;
    s = 0;
    avail = 0;
    for (; s < SLOTS_PER_BUCKET; s++) begin
      if (avail == need) break;
      if (!valid_mem[b][s]) avail++;
      else avail = 0;
    end
    if (avail >= need) begin
      a.start_slot = (s >= need) ? 6'(s - need) : 6'd0;
      a.status = ST_FREE;
      return a;
    end
    if (len_mem[b] == 0) begin
      a.start_slot = 6'd0;
      a.status = ST_EMPTY;
      return a;
    end
    s = order_mem[b][len_mem[b]-1];
    k = key_mem[b][s];
    while (avail < need && s < SLOTS_PER_BUCKET) begin
      if (valid_mem[b][s] && key_mem[b][s] == k) avail++;
      s++;
    end
    a.start_slot = (s >= need) ? 6'(s - need) : 6'd0;
    a.status = (avail >= need) ? ST_EVICT : ST_OFF_END;
    return a;
  endfunction

  function automatic answer_t predict_answer(mode_e m, int b, int s, int need,
                                             logic v, logic [31:0] k);
    answer_t a;
    a.start_slot = 6'd0;
    a.status = ST_DONE;
    case (m)
      MODE_PROMOTE: shadow_promote(b, s);
      MODE_ALLOC:   a = shadow_allocate(b, need);
      MODE_WRITE: begin
        valid_mem[b][s] = v;
        key_mem[b][s] = k[KEY_BITS-1:0];
      end
      default: ;
    endcase
    return a;
  endfunction

  task automatic send_word(mode_e m, logic [7:0] b, logic [4:0] s, logic [5:0] need,
                           logic v, logic [31:0] k);
    mode_i = m;
    bucket_index_i = b;
    slot_i = s;
    slots_needed_i = need;
    valid_in_i = v;
    key_in_i = k;
    start_i = 1'b1;
    @(posedge clk_i);
    while (busy_o) @(posedge clk_i);
    pending_answers.push_back(predict_answer(m, b, s, need, v, k));
    @(negedge clk_i);
    start_i = 1'b0;
  endtask

  task automatic wait_drained();
    while (pending_answers.size() != 0) @(negedge clk_i);
  endtask

  task automatic random_gap();
    if ($urandom_range(0, 3) == 0)
      repeat ($urandom_range(1, 40)) @(negedge clk_i);
  endtask

  always @(posedge clk_i) begin
    answer_t want;
    if (rst_ni && done_o) begin
      if (pending_answers.size() == 0) begin
        $display("%0t: unexpected word start_slot=%0d status=%0d", $time,
                 start_slot_o, status_o);
        errors++;
      end else begin
        want = pending_answers.pop_front();
        if (start_slot_o !== want.start_slot) begin
          $display("%0t: start_slot expected %0d actual %0d", $time,
                   want.start_slot, start_slot_o);
          errors++;
        end
        if (status_o !== want.status) begin
          $display("%0t: status expected %0d actual %0d", $time,
                   want.status, status_o);
          errors++;
        end
      end
    end
  end

  task automatic test_directed();
    send_word(MODE_ALLOC, 8'd0, 5'd0, 6'd0, 1'b0, 32'd0);
    send_word(MODE_ALLOC, 8'd0, 5'd0, 6'd32, 1'b0, 32'd0);
    send_word(MODE_NOP, 8'hff, 5'h1f, 6'h3f, 1'b1, 32'hffff_ffff);
    for (int s = 0; s < SLOTS_PER_BUCKET; s++)
      send_word(MODE_WRITE, 8'd1, 5'(s), 6'd0, 1'b1, 32'hffff_ffff);
    // Full bucket with an empty recency list.
    send_word(MODE_ALLOC, 8'd1, 5'd0, 6'd1, 1'b0, 32'd0);
    send_word(MODE_PROMOTE, 8'd1, 5'd31, 6'd0, 1'b0, 32'd0);
    send_word(MODE_PROMOTE, 8'd1, 5'd4, 6'd0, 1'b0, 32'd0);
    send_word(MODE_PROMOTE, 8'd1, 5'd31, 6'd0, 1'b0, 32'd0);
    send_word(MODE_ALLOC, 8'd1, 5'd0, 6'd3, 1'b0, 32'd0);
    send_word(MODE_ALLOC, 8'd1, 5'd0, 6'd32, 1'b0, 32'd0);
    send_word(MODE_ALLOC, 8'd1, 5'd0, 6'd63, 1'b0, 32'd0);
    send_word(MODE_WRITE, 8'd1, 5'd2, 6'd0, 1'b0, 32'h0);
    send_word(MODE_ALLOC, 8'd1, 5'd0, 6'd1, 1'b0, 32'd0);
    send_word(MODE_ALLOC, 8'd255, 5'd0, 6'd1, 1'b0, 32'd0);
    wait_drained();
  endtask

  task automatic test_full_list();
    for (int s = 0; s < SLOTS_PER_BUCKET; s++)
      send_word(MODE_PROMOTE, 8'd2, 5'(s), 6'd0, 1'b0, 32'd0);
    send_word(MODE_PROMOTE, 8'd2, 5'd0, 6'd0, 1'b0, 32'd0);
    send_word(MODE_ALLOC, 8'd2, 5'd0, 6'd33, 1'b0, 32'd0);
  endtask

  task automatic test_random(int count);
    mode_e m;
    logic [7:0] b;
    int n;
    for (int j = 0; j < 4; j++) hot_bucket[j] = 8'($urandom);
    n = 0;
    while (n < count) begin
      int burst;
      burst = $urandom_range(1, 20);
      for (int i = 0; i < burst && n < count; i++) begin
        m = mode_e'($urandom_range(0, 9) < 9 ? $urandom_range(0, 2) : 3);
        b = ($urandom_range(0, 9) < 8) ? hot_bucket[$urandom_range(0, 3)]
                                       : 8'($urandom);
        send_word(m, b, 5'($urandom), 6'($urandom_range(0, 9) < 8 ?
                  $urandom_range(0, 6) : $urandom_range(0, 63)),
                  ($urandom_range(0, 3) != 0), ($urandom_range(0, 1) ?
                  32'($urandom_range(0, 2)) : $urandom));
        n++;
      end
      repeat ($urandom_range(0, 30)) @(negedge clk_i);
      if (n == count / 2) wait_drained();
    end
  endtask

  initial begin
    for (int b = 0; b < NUM_BUCKETS; b++) begin
      len_mem[b] = 0;
      for (int s = 0; s < SLOTS_PER_BUCKET; s++) begin
        order_mem[b][s] = '0;
        valid_mem[b][s] = 1'b0;
        key_mem[b][s] = '0;
      end
    end
    rst_ni = 1'b0;
    start_i = 1'b0;
    mode_i = MODE_NOP;
    bucket_index_i = '0;
    slot_i = '0;
    slots_needed_i = '0;
    valid_in_i = 1'b0;
    key_in_i = '0;
    repeat (11) @(negedge clk_i);
    rst_ni = 1'b1;
    test_directed();
    test_full_list();
    random_gap();
    test_random(600);
    wait_drained();
    repeat (100) @(negedge clk_i);
    if (errors == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

  initial begin
    #2000000;
    $display("Some tests failed");
    $finish;
  end

endmodule

// ===== files.f =====
design/lsa_pkg.sv
design/lsa_ram.sv
design/lru_slot_allocator.sv
tb/tb_lru_slot_allocator.sv
